// ===== rtl/erl_pkg.sv =====
// Package for the event ring log: field widths, request and register codes,
// the entry and result item types, and the query filter function.
// Depends on nothing; every other file of the block imports it.
package erl_pkg;

   localparam int TIME_W     = 48;
   localparam int LEVEL_W    = 2;
   localparam int KIND_W     = 3;
   localparam int REQ_W      = 3;
   localparam int CNT_W      = 8;
   localparam int STAT_ID_W  = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int NUM_LEVELS = 3;
   localparam int NUM_KIND_STATS = 5;

   // Request codes.
   localparam logic [REQ_W-1:0] REQ_RECORD  = 3'd0;
   localparam logic [REQ_W-1:0] REQ_QUERY   = 3'd1;
   localparam logic [REQ_W-1:0] REQ_RECENT  = 3'd2;
   localparam logic [REQ_W-1:0] REQ_SUMMARY = 3'd3;
   localparam logic [REQ_W-1:0] REQ_CLEAR   = 3'd4;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SEVERITY = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CAT_FILTER_ON = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CAT_SELECT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_START = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_END   = 3'd4;

   // Severity codes.
   localparam logic [LEVEL_W-1:0] LEVEL_INFO = 2'd0;
   localparam logic [LEVEL_W-1:0] LEVEL_WARN = 2'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_CRIT = 2'd2;

   // Summary statistic identifiers.
   localparam logic [STAT_ID_W-1:0] STAT_TOTAL     = 4'd0;
   localparam logic [STAT_ID_W-1:0] STAT_INFO      = 4'd1;
   localparam logic [STAT_ID_W-1:0] STAT_WARN      = 4'd2;
   localparam logic [STAT_ID_W-1:0] STAT_CRIT      = 4'd3;
   localparam logic [STAT_ID_W-1:0] STAT_CRIT_TIME = 4'd4;
   localparam logic [STAT_ID_W-1:0] STAT_CAT0      = 4'd5;
   localparam logic [STAT_ID_W-1:0] STAT_CAT1      = 4'd6;
   localparam logic [STAT_ID_W-1:0] STAT_CAT2      = 4'd7;
   localparam logic [STAT_ID_W-1:0] STAT_CAT3      = 4'd8;
   localparam logic [STAT_ID_W-1:0] STAT_CAT4      = 4'd9;

   typedef struct packed {
      logic [TIME_W-1:0]  ts;
      logic [LEVEL_W-1:0] lvl;
      logic [KIND_W-1:0]  kind;
   } erl_entry_type;

   // Control from the sequencer to the chain of cells.
   typedef struct packed {
      logic shift;  // every cell takes its neighbor's entry
      logic load;   // the first cell takes the new event instead of the wrapped tap
   } erl_chain_ctl_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] min_sev;
      logic               cat_on;
      logic [KIND_W-1:0]  cat_sel;
      logic [TIME_W-1:0]  win_start;
      logic [TIME_W-1:0]  win_end;
   } erl_cfg_type;

   typedef struct packed {
      erl_entry_type        ent;
      logic [STAT_ID_W-1:0] stat_id;
      logic [TIME_W-1:0]    stat_value;
      logic                 is_summary;
      logic                 is_empty;
      logic                 is_last;
   } erl_rsp_type;

   // True when an entry passes the configured query filter.
   function automatic logic erl_passes(input erl_entry_type e, input erl_cfg_type c);
      logic ok;
      ok = (e.lvl >= c.min_sev);
      if (c.cat_on && (e.kind != c.cat_sel)) ok = 1'b0;
      if ((c.win_start != '0) && (e.ts < c.win_start)) ok = 1'b0;
      if ((c.win_end != '0) && (e.ts > c.win_end)) ok = 1'b0;
      return ok;
   endfunction

   function automatic erl_rsp_type erl_entry_rsp(input erl_entry_type e, input logic last);
      erl_rsp_type r;
      r = '0;
      r.ent = e;
      r.is_last = last;
      return r;
   endfunction

   function automatic erl_rsp_type erl_empty_rsp();
      erl_rsp_type r;
      r = '0;
      r.is_empty = 1'b1;
      r.is_last = 1'b1;
      return r;
   endfunction

   function automatic erl_rsp_type erl_stat_rsp(input logic [STAT_ID_W-1:0] id,
                                                input logic [TIME_W-1:0] val);
      erl_rsp_type r;
      r = '0;
      r.stat_id = id;
      r.stat_value = val;
      r.is_summary = 1'b1;
      r.is_last = (id == STAT_CAT4);
      return r;
   endfunction

endpackage

// ===== rtl/erl_if.sv =====
// Channel interfaces of the event ring log: request, result and register write.
// Depends on erl_pkg for the field widths.

interface erl_req_if import erl_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [REQ_W-1:0]   req_type;
   logic [TIME_W-1:0]  event_time;
   logic [LEVEL_W-1:0] event_level;
   logic [KIND_W-1:0]  event_kind;
   logic [CNT_W-1:0]   recent_count;

   modport source (output valid, req_type, event_time, event_level, event_kind,
                   recent_count, input ready);
   modport sink   (input valid, req_type, event_time, event_level, event_kind,
                   recent_count, output ready);
endinterface

interface erl_rsp_if import erl_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [TIME_W-1:0]    out_time;
   logic [LEVEL_W-1:0]   out_level;
   logic [KIND_W-1:0]    out_kind;
   logic [STAT_ID_W-1:0] stat_id;
   logic [TIME_W-1:0]    stat_value;
   logic                 is_summary;
   logic                 is_empty;
   logic                 is_last;

   modport source (output valid, out_time, out_level, out_kind, stat_id, stat_value,
                   is_summary, is_empty, is_last, input ready);
   modport sink   (input valid, out_time, out_level, out_kind, stat_id, stat_value,
                   is_summary, is_empty, is_last, output ready);
endinterface

interface erl_csr_if import erl_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [TIME_W-1:0]    wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

// ===== rtl/erl_cell.sv =====
// One storage cell of the log chain: holds one event entry.
// Depends on erl_pkg for the entry type.
module erl_cell
   import erl_pkg::*;
(
   input  logic          clock,
   input  logic          shift,
   input  erl_entry_type prev,
   output erl_entry_type entry
);

   erl_entry_type entry_ff;
   erl_entry_type entry_in;

   // Take the neighbor's entry when the chain moves.
   always_comb begin
      entry_in = shift ? prev : entry_ff;
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ===== rtl/erl_chain.sv =====
// Row of DEPTH log cells. Cell 0 holds the newest entry; the last cell is the
// tap that wraps back to cell 0 while the log is rotated for a readout.
// Depends on erl_pkg and erl_cell.
module erl_chain
   import erl_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic              clock,
   input  erl_chain_ctl_type ctl,
   input  erl_entry_type     new_entry,
   output erl_entry_type     tap
);

   erl_entry_type cell_q [DEPTH];
   erl_entry_type head_d;

   // The first cell takes a new event on a record, else the wrapped tap.
   always_comb begin
      head_d = ctl.load ? new_entry : cell_q[DEPTH-1];
   end

   erl_cell u_cell_0 (
      .clock (clock),
      .shift (ctl.shift),
      .prev  (head_d),
      .entry (cell_q[0])
   );

   for (genvar g = 1; g < DEPTH; g++) begin : g_cell
      erl_cell u_cell (
         .clock (clock),
         .shift (ctl.shift),
         .prev  (cell_q[g-1]),
         .entry (cell_q[g])
      );
   end

   assign tap = cell_q[DEPTH-1];

endmodule

// ===== rtl/event_ring_log_filtered_readout.sv =====
// Channel  Direction  Handshake          Payload
// req_bus  in         valid/ready        req_type, event_time, event_level, event_kind,
//                                        recent_count
// rsp_bus  out        valid/ready        out_time, out_level, out_kind, stat_id,
//                                        stat_value, is_summary, is_empty, is_last
// csr_bus  in         valid/ready        index, wdata (ready is always high)
//
// Record and clear items are taken back to back.
// Query, recent and summary items rotate the whole chain once after they are accepted:
// a scan over every cell, then the final result of a query or recent run, or the ten
// results of a summary.
// A full result register that is not taken holds the scan.
// Reset (synchronous, active high) empties the log and clears the registers.
// Depends on erl_pkg, erl_if and erl_chain.
module event_ring_log_filtered_readout
   import erl_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input logic       clock,
   input logic       reset,
   erl_req_if.sink   req_bus,
   erl_rsp_if.source rsp_bus,
   erl_csr_if.sink   csr_bus
);

   localparam int K_W   = $clog2(DEPTH);
   localparam int OCC_W = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FINISH, ST_SUMM} state_type;

   state_type            state_ff, state_in;
   logic [OCC_W-1:0]     occ_ff, occ_in;
   logic [K_W-1:0]       k_ff, k_in;
   logic [OCC_W-1:0]     lo_ff, lo_in;
   logic [REQ_W-1:0]     op_ff, op_in;
   erl_entry_type        pend_ff, pend_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [STAT_ID_W-1:0] sidx_ff, sidx_in;
   logic [OCC_W-1:0]     lvl_cnt_ff [NUM_LEVELS];
   logic [OCC_W-1:0]     lvl_cnt_in [NUM_LEVELS];
   logic [OCC_W-1:0]     kind_cnt_ff [NUM_KIND_STATS];
   logic [OCC_W-1:0]     kind_cnt_in [NUM_KIND_STATS];
   logic [TIME_W-1:0]    crit_max_ff, crit_max_in;
   erl_cfg_type          cfg_ff, cfg_in;
   erl_rsp_type          rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   erl_chain_ctl_type    chain_ctl;
   erl_entry_type        new_entry;
   erl_entry_type        tap;
   logic                 can_load;
   logic                 in_range;
   logic                 take;
   logic                 req_fire;
   logic [OCC_W-1:0]     recent_eff;
   logic [TIME_W-1:0]    stat_val;

   erl_chain #(.DEPTH(DEPTH)) u_chain (
      .clock     (clock),
      .ctl       (chain_ctl),
      .new_entry (new_entry),
      .tap       (tap)
   );

   assign new_entry.ts   = req_bus.event_time;
   assign new_entry.lvl  = req_bus.event_level;
   assign new_entry.kind = req_bus.event_kind;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign csr_bus.ready = 1'b1;
   assign req_fire      = req_bus.valid && (state_ff == ST_IDLE);

   // The result register may be loaded when it is empty or drains this cycle.
   assign can_load = !rsp_valid_ff || rsp_bus.ready;

   // After k rotation steps the tap holds age position k - (DEPTH - occupancy).
   assign in_range = (OCC_W'(k_ff) >= lo_ff);
   assign take     = in_range && ((op_ff != REQ_QUERY) || erl_passes(tap, cfg_ff));

   // A recent count above occupancy returns every entry.
   assign recent_eff = (req_bus.recent_count > CNT_W'(occ_ff)) ? occ_ff
                                                               : OCC_W'(req_bus.recent_count);

   // Statistic selected for the current summary result.
   always_comb begin
      unique case (sidx_ff)
         STAT_TOTAL:     stat_val = TIME_W'(occ_ff);
         STAT_INFO:      stat_val = TIME_W'(lvl_cnt_ff[0]);
         STAT_WARN:      stat_val = TIME_W'(lvl_cnt_ff[1]);
         STAT_CRIT:      stat_val = TIME_W'(lvl_cnt_ff[2]);
         STAT_CRIT_TIME: stat_val = crit_max_ff;
         STAT_CAT0:      stat_val = TIME_W'(kind_cnt_ff[0]);
         STAT_CAT1:      stat_val = TIME_W'(kind_cnt_ff[1]);
         STAT_CAT2:      stat_val = TIME_W'(kind_cnt_ff[2]);
         STAT_CAT3:      stat_val = TIME_W'(kind_cnt_ff[3]);
         STAT_CAT4:      stat_val = TIME_W'(kind_cnt_ff[4]);
         default:        stat_val = '0;
      endcase
   end

   // Sequencer: next state of control, counters, result register and config.
   always_comb begin
      state_in      = state_ff;
      occ_in        = occ_ff;
      k_in          = k_ff;
      lo_in         = lo_ff;
      op_in         = op_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      sidx_in       = sidx_ff;
      lvl_cnt_in    = lvl_cnt_ff;
      kind_cnt_in   = kind_cnt_ff;
      crit_max_in   = crit_max_ff;
      cfg_in        = cfg_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      chain_ctl     = '0;

      // Register writes; indexes beyond the list are dropped.
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_MIN_SEVERITY:  cfg_in.min_sev   = csr_bus.wdata[LEVEL_W-1:0];
            CSR_CAT_FILTER_ON: cfg_in.cat_on    = csr_bus.wdata[0];
            CSR_CAT_SELECT:    cfg_in.cat_sel   = csr_bus.wdata[KIND_W-1:0];
            CSR_WINDOW_START:  cfg_in.win_start = csr_bus.wdata;
            CSR_WINDOW_END:    cfg_in.win_end   = csr_bus.wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_bus.req_type)
                  REQ_RECORD: begin
                     chain_ctl.shift = 1'b1;
                     chain_ctl.load  = 1'b1;
                     if (occ_ff != OCC_W'(DEPTH)) occ_in = occ_ff + 1'b1;
                  end
                  REQ_QUERY, REQ_RECENT, REQ_SUMMARY: begin
                     op_in         = req_bus.req_type;
                     k_in          = '0;
                     pend_valid_in = 1'b0;
                     sidx_in       = '0;
                     crit_max_in   = '0;
                     for (int j = 0; j < NUM_LEVELS; j++) lvl_cnt_in[j] = '0;
                     for (int j = 0; j < NUM_KIND_STATS; j++) kind_cnt_in[j] = '0;
                     if (req_bus.req_type == REQ_RECENT) begin
                        lo_in = OCC_W'(DEPTH) - recent_eff;
                     end else begin
                        lo_in = OCC_W'(DEPTH) - occ_ff;
                     end
                     state_in = ST_SCAN;
                  end
                  REQ_CLEAR: occ_in = '0;
                  default: ;
               endcase
            end
         end

         ST_SCAN: begin
            if (can_load) begin
               chain_ctl.shift = 1'b1;
               if (op_ff == REQ_SUMMARY) begin
                  // Gather statistics over stored entries only.
                  if (in_range) begin
                     for (int j = 0; j < NUM_LEVELS; j++) begin
                        if (tap.lvl == LEVEL_W'(j)) lvl_cnt_in[j] = lvl_cnt_ff[j] + 1'b1;
                     end
                     for (int j = 0; j < NUM_KIND_STATS; j++) begin
                        if (tap.kind == KIND_W'(j)) kind_cnt_in[j] = kind_cnt_ff[j] + 1'b1;
                     end
                     if ((tap.lvl == LEVEL_CRIT) && (tap.ts > crit_max_ff)) begin
                        crit_max_in = tap.ts;
                     end
                  end
               end else if (take) begin
                  // Hold back one entry so the final one can carry is_last.
                  if (pend_valid_ff) begin
                     rsp_in       = erl_entry_rsp(pend_ff, 1'b0);
                     rsp_valid_in = 1'b1;
                  end
                  pend_in       = tap;
                  pend_valid_in = 1'b1;
               end
               if (k_ff == K_W'(DEPTH - 1)) begin
                  k_in     = '0;
                  state_in = (op_ff == REQ_SUMMARY) ? ST_SUMM : ST_FINISH;
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end
         end

         ST_FINISH: begin
            if (can_load) begin
               rsp_in        = pend_valid_ff ? erl_entry_rsp(pend_ff, 1'b1) : erl_empty_rsp();
               rsp_valid_in  = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         ST_SUMM: begin
            if (can_load) begin
               rsp_in       = erl_stat_rsp(sidx_ff, stat_val);
               rsp_valid_in = 1'b1;
               if (sidx_ff == STAT_CAT4) begin
                  sidx_in  = '0;
                  state_in = ST_IDLE;
               end else begin
                  sidx_in = sidx_ff + 1'b1;
               end
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         occ_ff        <= '0;
         k_ff          <= '0;
         pend_valid_ff <= 1'b0;
         sidx_ff       <= '0;
         cfg_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         occ_ff        <= occ_in;
         k_ff          <= k_in;
         pend_valid_ff <= pend_valid_in;
         sidx_ff       <= sidx_in;
         cfg_ff        <= cfg_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      lo_ff       <= lo_in;
      op_ff       <= op_in;
      pend_ff     <= pend_in;
      lvl_cnt_ff  <= lvl_cnt_in;
      kind_cnt_ff <= kind_cnt_in;
      crit_max_ff <= crit_max_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.out_time   = rsp_ff.ent.ts;
   assign rsp_bus.out_level  = rsp_ff.ent.lvl;
   assign rsp_bus.out_kind   = rsp_ff.ent.kind;
   assign rsp_bus.stat_id    = rsp_ff.stat_id;
   assign rsp_bus.stat_value = rsp_ff.stat_value;
   assign rsp_bus.is_summary = rsp_ff.is_summary;
   assign rsp_bus.is_empty   = rsp_ff.is_empty;
   assign rsp_bus.is_last    = rsp_ff.is_last;

   // Occupancy never exceeds the log depth.
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(DEPTH))
      else $error("occupancy above depth");

   // The rotation counter rests at zero outside a scan, so the chain is back in order.
   a_k_rest: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_SCAN |-> k_ff == '0)
      else $error("rotation counter not at rest");

   // An empty result is always the single, final entry result of its run.
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.is_empty |-> rsp_ff.is_last && !rsp_ff.is_summary)
      else $error("empty result not final");

   // A record into a log that is not full grows it by one.
   a_record_grow: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_bus.req_type == REQ_RECORD) && (occ_ff != OCC_W'(DEPTH))
      |=> occ_ff == $past(occ_ff) + 1'b1)
      else $error("record did not grow occupancy");

endmodule

// ===== tb/tb_event_ring_log_filtered_readout.sv =====
// Self-checking testbench for the event ring log with filtered readout.
// It mirrors the log in a small class, drives record, query, recent, summary and
// clear items, and checks every readout item. It depends on erl_pkg, erl_if and event_ring_log_filtered_readout.
module tb_event_ring_log_filtered_readout;
   import erl_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LOG_DEPTH   = 64;
   localparam int CLK_PERIOD  = 10;
   localparam int SINK_HOLD   = 400;
   localparam int QUIET_LIMIT = 4000;
   localparam int DRAIN_WAIT  = LOG_DEPTH + 16;
   localparam logic [TIME_W-1:0] TIME_MAX = '1;

   // Mirror of the log contents and filter settings, plus the readout items
   // that the block still owes.
   class ring_log_mirror;
      logic [TIME_W-1:0]  ts_mem   [LOG_DEPTH];
      logic [LEVEL_W-1:0] lvl_mem  [LOG_DEPTH];
      logic [KIND_W-1:0]  kind_mem [LOG_DEPTH];
      int unsigned        head;
      int unsigned        fill;
      erl_cfg_type        cfg;
      erl_rsp_type        readout_q[$];
      int unsigned        errors;
      int unsigned        checked;

      function new();
         head    = 0;
         fill    = 0;
         cfg     = '0;
         errors  = 0;
         checked = 0;
      endfunction

      function void set_reg(input logic [CSR_IDX_W-1:0] idx, input logic [TIME_W-1:0] val);
         case (idx)
            CSR_MIN_SEVERITY:  cfg.min_sev   = val[LEVEL_W-1:0];
            CSR_CAT_FILTER_ON: cfg.cat_on    = val[0];
            CSR_CAT_SELECT:    cfg.cat_sel   = val[KIND_W-1:0];
            CSR_WINDOW_START:  cfg.win_start = val;
            CSR_WINDOW_END:    cfg.win_end   = val;
            default: ;
         endcase
      endfunction

      // Slot that holds the entry of the given age, zero being the oldest.
      function int unsigned slot_of(input int unsigned age);
         return (head + LOG_DEPTH - fill + age) % LOG_DEPTH;
      endfunction

      function bit keeps(input int unsigned s);
         if (lvl_mem[s] < cfg.min_sev) return 1'b0;
         if (cfg.cat_on && (kind_mem[s] != cfg.cat_sel)) return 1'b0;
         if ((cfg.win_start != '0) && (ts_mem[s] < cfg.win_start)) return 1'b0;
         if ((cfg.win_end != '0) && (ts_mem[s] > cfg.win_end)) return 1'b0;
         return 1'b1;
      endfunction

      function erl_rsp_type entry_item(input int unsigned s, input logic last);
         erl_rsp_type r;
         r          = '0;
         r.ent.ts   = ts_mem[s];
         r.ent.lvl  = lvl_mem[s];
         r.ent.kind = kind_mem[s];
         r.is_last  = last;
         return r;
      endfunction

      // Append one readout item to the list of items still owed.
      function void owe(input erl_rsp_type r);
         readout_q = {readout_q, r};
      endfunction

      function void push_empty();
         erl_rsp_type r;
         r          = '0;
         r.is_empty = 1'b1;
         r.is_last  = 1'b1;
         owe(r);
      endfunction

      // Update the mirror for one accepted request and queue what it reads out.
      function void take_request(input logic [REQ_W-1:0] rt, input logic [TIME_W-1:0] ts,
                                 input logic [LEVEL_W-1:0] lvl, input logic [KIND_W-1:0] kind,
                                 input logic [CNT_W-1:0] cnt);
         int unsigned       n;
         int unsigned       s;
         int unsigned       take;
         int unsigned       age;
         int unsigned       i;
         logic [TIME_W-1:0] stats [10];
         erl_rsp_type       r;
         case (rt)
            REQ_RECORD: begin
               ts_mem[head]   = ts;
               lvl_mem[head]  = lvl;
               kind_mem[head] = kind;
               head = (head + 1) % LOG_DEPTH;
               if (fill < LOG_DEPTH) fill++;
            end
            REQ_QUERY: begin
               n = 0;
               for (age = 0; age < fill; age++) begin
                  s = slot_of(age);
                  if (keeps(s)) begin
                     owe(entry_item(s, 1'b0));
                     n++;
                  end
               end
               if (n == 0) push_empty();
               else readout_q[readout_q.size()-1].is_last = 1'b1;
            end
            REQ_RECENT: begin
               take = (cnt > fill) ? fill : cnt;
               if (take == 0) begin
                  push_empty();
               end else begin
                  for (age = fill - take; age < fill; age++)
                     owe(entry_item(slot_of(age), age + 1 == fill));
               end
            end
            REQ_SUMMARY: begin
               for (i = 0; i < 10; i++) stats[i] = '0;
               stats[STAT_TOTAL] = TIME_W'(fill);
               for (age = 0; age < fill; age++) begin
                  s = slot_of(age);
                  // Severity 3 and categories above 4 only count in the total.
                  if (lvl_mem[s] < NUM_LEVELS) stats[int'(STAT_INFO) + lvl_mem[s]] += 1;
                  if ((lvl_mem[s] == LEVEL_CRIT) && (ts_mem[s] > stats[STAT_CRIT_TIME]))
                     stats[STAT_CRIT_TIME] = ts_mem[s];
                  if (kind_mem[s] < NUM_KIND_STATS) stats[int'(STAT_CAT0) + kind_mem[s]] += 1;
               end
               for (i = 0; i < 10; i++) begin
                  r            = '0;
                  r.stat_id    = STAT_ID_W'(i);
                  r.stat_value = stats[i];
                  r.is_summary = 1'b1;
                  r.is_last    = (i == STAT_CAT4);
                  owe(r);
               end
            end
            REQ_CLEAR: begin
               fill = 0;
               head = 0;
            end
            default: ;
         endcase
      endfunction

      function bit same(input string name, input logic [TIME_W-1:0] want,
                        input logic [TIME_W-1:0] seen);
         if (want !== seen) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
            return 1'b0;
         end
         return 1'b1;
      endfunction

      // Compare one accepted readout item with the oldest one owed.
      function void check_readout(input erl_rsp_type got);
         erl_rsp_type want;
         bit          ok;
         if (readout_q.size() == 0) begin
            $display("%0t: unexpected readout item, expected none, actual %0h", $time, got);
            errors++;
            return;
         end
         want = readout_q.pop_front();
         checked++;
         ok = 1'b1;
         ok &= same("out_time", want.ent.ts, got.ent.ts);
         ok &= same("out_level", want.ent.lvl, got.ent.lvl);
         ok &= same("out_kind", want.ent.kind, got.ent.kind);
         ok &= same("stat_id", want.stat_id, got.stat_id);
         ok &= same("stat_value", want.stat_value, got.stat_value);
         ok &= same("is_summary", want.is_summary, got.is_summary);
         ok &= same("is_empty", want.is_empty, got.is_empty);
         ok &= same("is_last", want.is_last, got.is_last);
         if (!ok) errors++;
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   erl_req_if req_bus ();
   erl_rsp_if rsp_bus ();
   erl_csr_if csr_bus ();

   ring_log_mirror log_mirror = new();
   erl_rsp_type    seen_rsp;
   int unsigned    quiet_cycles = 0;
   int unsigned    sent_by_type [8];
   int unsigned    settings_used = 0;
   bit             src_idle  = 1'b1;
   bit             sink_idle = 1'b1;
   bit             hold_sink = 1'b0;

   event_ring_log_filtered_readout #(
      .DEPTH (LOG_DEPTH)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #(CLK_PERIOD/2) clock = ~clock;

   // Sample every handshake at the clock edge and watch for a stuck run.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            log_mirror.take_request(req_bus.req_type, req_bus.event_time, req_bus.event_level,
                                    req_bus.event_kind, req_bus.recent_count);
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen_rsp.ent.ts     = rsp_bus.out_time;
            seen_rsp.ent.lvl    = rsp_bus.out_level;
            seen_rsp.ent.kind   = rsp_bus.out_kind;
            seen_rsp.stat_id    = rsp_bus.stat_id;
            seen_rsp.stat_value = rsp_bus.stat_value;
            seen_rsp.is_summary = rsp_bus.is_summary;
            seen_rsp.is_empty   = rsp_bus.is_empty;
            seen_rsp.is_last    = rsp_bus.is_last;
            log_mirror.check_readout(seen_rsp);
         end
         if (csr_bus.valid && csr_bus.ready)
            log_mirror.set_reg(csr_bus.index, csr_bus.wdata);
      end
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
         $display("simulation failed");
         $finish;
      end
   end

   // Result receiver: random stall bursts, and one long hold-off on request.
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_sink) begin
            rsp_bus.ready <= 1'b0;
            repeat (SINK_HOLD) @(posedge clock);
            hold_sink = 1'b0;
         end else if (sink_idle && ($urandom_range(0, 5) == 0)) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
      end
   end

   // Offer one request item and hold it until taken, then maybe pause.
   task automatic send_req(input logic [REQ_W-1:0] rt, input logic [TIME_W-1:0] ts,
                           input logic [LEVEL_W-1:0] lvl, input logic [KIND_W-1:0] kind,
                           input logic [CNT_W-1:0] cnt);
      req_bus.valid        <= 1'b1;
      req_bus.req_type     <= rt;
      req_bus.event_time   <= ts;
      req_bus.event_level  <= lvl;
      req_bus.event_kind   <= kind;
      req_bus.recent_count <= cnt;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sent_by_type[rt]++;
      if (src_idle && ($urandom_range(0, 3) == 0)) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [TIME_W-1:0] val);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.wdata <= val;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
   endtask

   task automatic configure(input logic [LEVEL_W-1:0] min_sev, input logic cat_on,
                            input logic [KIND_W-1:0] cat_sel, input logic [TIME_W-1:0] win_lo,
                            input logic [TIME_W-1:0] win_hi);
      csr_write(CSR_MIN_SEVERITY, min_sev);
      csr_write(CSR_CAT_FILTER_ON, cat_on);
      csr_write(CSR_CAT_SELECT, cat_sel);
      csr_write(CSR_WINDOW_START, win_lo);
      csr_write(CSR_WINDOW_END, win_hi);
      csr_bus.valid <= 1'b0;
      settings_used++;
   endtask

   // Let every owed readout item arrive, then allow the scan to settle.
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (log_mirror.readout_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // Timestamps cluster in a small range so that windows bite, with extremes mixed in.
   function automatic logic [TIME_W-1:0] pick_time();
      int unsigned sel;
      logic [63:0] wide;
      sel  = $urandom_range(0, 15);
      wide = {$urandom, $urandom};
      case (sel)
         0:       return '0;
         1:       return TIME_MAX;
         2, 3:    return wide[TIME_W-1:0];
         default: return $urandom_range(0, 4095);
      endcase
   endfunction

   function automatic logic [CNT_W-1:0] pick_count();
      case ($urandom_range(0, 3))
         0:       return $urandom_range(0, 3);
         1:       return $urandom_range(0, 20);
         2:       return '1;
         default: return $urandom_range(0, 255);
      endcase
   endfunction

   // Random mix, mostly records so the log fills and wraps; unknown codes do not count.
   task automatic run_random(input int unsigned count, input bit allow_clear);
      int unsigned       made;
      int unsigned       r;
      logic [REQ_W-1:0]  rt;
      made = 0;
      while (made < count) begin
         r = $urandom_range(0, 99);
         if (r < 52)                       rt = REQ_RECORD;
         else if (r < 66)                  rt = REQ_QUERY;
         else if (r < 78)                  rt = REQ_RECENT;
         else if (r < 86)                  rt = REQ_SUMMARY;
         else if (r < 92)                  rt = REQ_CLEAR + REQ_W'($urandom_range(1, 3));
         else if (allow_clear && r >= 97)  rt = REQ_CLEAR;
         else                              rt = REQ_RECORD;
         send_req(rt, pick_time(), $urandom_range(0, 3), $urandom_range(0, 7), pick_count());
         if (rt <= REQ_CLEAR) made++;
      end
   endtask

   initial begin
      logic [TIME_W-1:0] win_lo;
      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.req_type     <= REQ_RECORD;
      req_bus.event_time   <= '0;
      req_bus.event_level  <= LEVEL_INFO;
      req_bus.event_kind   <= '0;
      req_bus.recent_count <= '0;
      csr_bus.valid        <= 1'b0;
      csr_bus.index        <= CSR_MIN_SEVERITY;
      csr_bus.wdata        <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: readouts of an empty log, then a small log with edge values.
      configure(LEVEL_INFO, 1'b0, 3'd0, '0, '0);
      send_req(REQ_QUERY, '0, LEVEL_INFO, 3'd0, '0);
      send_req(REQ_RECENT, '0, LEVEL_INFO, 3'd0, 8'd5);
      send_req(REQ_SUMMARY, '0, LEVEL_INFO, 3'd0, '0);
      send_req(REQ_RECORD, '0, LEVEL_INFO, 3'd0, '0);
      send_req(REQ_RECORD, TIME_MAX, LEVEL_CRIT, 3'd6, '0);
      send_req(REQ_RECORD, 48'd1000, 2'd3, 3'd7, '0);
      send_req(REQ_RECORD, 48'd1234, LEVEL_WARN, 3'd4, '0);
      send_req(REQ_RECORD, 48'd500, LEVEL_CRIT, 3'd5, '0);
      send_req(REQ_RECORD, 48'd42, LEVEL_CRIT, 3'd3, '0);
      send_req(REQ_QUERY, '0, LEVEL_INFO, 3'd0, '0);
      send_req(REQ_RECENT, '0, LEVEL_INFO, 3'd0, 8'd0);
      send_req(REQ_RECENT, '0, LEVEL_INFO, 3'd0, 8'd2);
      send_req(REQ_RECENT, '0, LEVEL_INFO, 3'd0, 8'd255);
      send_req(REQ_SUMMARY, '0, LEVEL_INFO, 3'd0, '0);
      send_req(REQ_CLEAR + 3'd1, 48'd7, LEVEL_CRIT, 3'd1, 8'd9);
      send_req(REQ_CLEAR + 3'd3, TIME_MAX, 2'd3, 3'd7, 8'd255);

      // Filters: a tight window with category, an open-ended start at the top
      // of the time range, and a filter that matches nothing in the small log.
      wait_idle();
      configure(LEVEL_CRIT, 1'b1, 3'd3, 48'd40, 48'd50);
      send_req(REQ_QUERY, '0, LEVEL_INFO, 3'd0, '0);
      wait_idle();
      configure(LEVEL_INFO, 1'b0, 3'd6, TIME_MAX, '0);
      send_req(REQ_QUERY, '0, LEVEL_INFO, 3'd0, '0);
      wait_idle();
      configure(LEVEL_WARN, 1'b1, 3'd6, '0, 48'd1000);
      send_req(REQ_QUERY, '0, LEVEL_INFO, 3'd0, '0);
      send_req(REQ_CLEAR, '0, LEVEL_INFO, 3'd0, '0);
      send_req(REQ_SUMMARY, '0, LEVEL_INFO, 3'd0, '0);
      send_req(REQ_RECENT, '0, LEVEL_INFO, 3'd0, 8'd3);

      // Random phases; no clears until the last so the log wraps.
      wait_idle();
      configure(LEVEL_INFO, 1'b0, 3'd0, '0, '0);
      run_random(32, 1'b0);
      wait_idle();
      configure(LEVEL_WARN, 1'b1, $urandom_range(0, 6), $urandom_range(0, 2048), '0);
      run_random(32, 1'b0);

      // The receiver holds off while full-log readouts back up the block.
      wait_idle();
      configure(LEVEL_CRIT, 1'b0, 3'd6, '0, TIME_MAX);
      hold_sink = 1'b1;
      send_req(REQ_RECENT, '0, LEVEL_INFO, 3'd0, 8'd255);
      send_req(REQ_QUERY, '0, LEVEL_INFO, 3'd0, '0);
      run_random(32, 1'b0);

      // Last phase runs at full rate on both sides.
      wait_idle();
      src_idle  = 1'b0;
      sink_idle = 1'b0;
      win_lo = $urandom_range(0, 2048);
      configure($urandom_range(0, 2), 1'b1, 3'd0, win_lo, win_lo + $urandom_range(0, 2048));
      run_random(32, 1'b1);
      wait_idle();

      $display("Sent %0d records, %0d queries, %0d recent, %0d summaries, %0d clears, %0d ignored.",
               sent_by_type[REQ_RECORD], sent_by_type[REQ_QUERY], sent_by_type[REQ_RECENT],
               sent_by_type[REQ_SUMMARY], sent_by_type[REQ_CLEAR],
               sent_by_type[5] + sent_by_type[6] + sent_by_type[7]);
      $display("Checked %0d readout items under %0d filter settings, %0d mismatches.",
               log_mirror.checked, settings_used, log_mirror.errors);
      if (log_mirror.errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
